FILE: design/rgbhsv_pkg.sv
// Shared types, constants and the one-bit division step for the RGB to HSV pipeline.
package rgbhsv_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned HueW      = 9;
  localparam int unsigned SectW     = 11;
  localparam int unsigned NumW      = 17;
  localparam int unsigned DivSteps  = 9;
  localparam int unsigned HueScale  = 60;
  localparam int unsigned SatScale  = 255;
  localparam int unsigned WrapSect  = 6;

  typedef logic [ChanW-1:0] chan_t;

  // partial remainder plus a shift register that feeds numerator bits out
  // at the top and takes quotient bits in at the bottom
  typedef struct packed {
    chan_t               rem;
    logic [DivSteps-1:0] nq;
  } lane_t;

  typedef struct packed {
    chan_t            value;
    chan_t            delta;
    logic [SectW-1:0] sect;
    logic             gray;
  } sort_t;

  typedef struct packed {
    chan_t value;
    chan_t delta;
    logic  gray;
    lane_t hue;
    lane_t sat;
  } div_t;

  function automatic lane_t div_step(lane_t l, chan_t d);
    lane_t          res;
    logic [ChanW:0] trial;
    trial = {l.rem, l.nq[DivSteps-1]};
    if (trial >= {1'b0, d}) begin
      res.rem = ChanW'(trial - {1'b0, d});
      res.nq  = {l.nq[DivSteps-2:0], 1'b1};
    end else begin
      res.rem = trial[ChanW-1:0];
      res.nq  = {l.nq[DivSteps-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

FILE: design/rgb_to_hsv.sv
// Top level of the pipelined 8-bit RGB to HSV converter.
//
// channel  signals                                   direction
// input    in_valid_i in_ready_o red/green/blue_i    word in
// output   out_valid_o out_ready_i hue/sat/value_o   word out
//
// One word per cycle sustained while out_ready_i stays high; registered stages in order: sort,
// scale, nine divider stages (the nine-step hue/saturation divider), output register.
// Reset clears only the valid bits; no warm-up after reset.
// Each stage holds when the next is full, so bubbles collapse and a stall
// on the output fills the pipeline before in_ready_o drops.
module rgb_to_hsv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 red_i,
  input  logic [7:0]                 green_i,
  input  logic [7:0]                 blue_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [8:0]                 hue_degrees_o,
  output logic [7:0]                 saturation_o,
  output logic [7:0]                 value_level_o
);
  import rgbhsv_pkg::*;

  logic  sort_valid, sort_ready;
  sort_t sort_data;

  logic  pipe_valid [DivSteps+1];
  logic  pipe_ready [DivSteps+1];
  div_t  pipe_data  [DivSteps+1];

  logic           out_valid_q;
  logic [HueW-1:0] hue_q, hue_d;
  chan_t          sat_q, sat_d, val_q;
  div_t           last;

  rgbhsv_sort u_sort (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (sort_valid),
    .ready_i (sort_ready),
    .data_o  (sort_data)
  );

  rgbhsv_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sort_valid),
    .ready_o (sort_ready),
    .data_i  (sort_data),
    .valid_o (pipe_valid[0]),
    .ready_i (pipe_ready[0]),
    .data_o  (pipe_data[0])
  );

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    rgbhsv_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pipe_valid[k]),
      .ready_o (pipe_ready[k]),
      .data_i  (pipe_data[k]),
      .valid_o (pipe_valid[k+1]),
      .ready_i (pipe_ready[k+1]),
      .data_o  (pipe_data[k+1])
    );
  end

  assign last = pipe_data[DivSteps];
  assign pipe_ready[DivSteps] = ~out_valid_q | out_ready_i;

  always_comb begin
    hue_d = last.gray ? '0 : last.hue.nq;
    sat_d = last.gray ? '0 : last.sat.nq[ChanW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_ready[DivSteps]) begin
      out_valid_q <= pipe_valid[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_valid[DivSteps] && pipe_ready[DivSteps]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= last.value;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hue_degrees_o = hue_q;
  assign saturation_o  = sat_q;
  assign value_level_o = val_q;

endmodule

FILE: design/rgbhsv_sort.sv
// First stage: max, min, delta and the hue sector term in units of delta.
module rgbhsv_sort (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  rgbhsv_pkg::chan_t    red_i,
  input  rgbhsv_pkg::chan_t    green_i,
  input  rgbhsv_pkg::chan_t    blue_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rgbhsv_pkg::sort_t    data_o
);
  import rgbhsv_pkg::*;

  logic              valid_q;
  sort_t             data_q, data_d;
  chan_t             mx, mn, delta;
  logic              r_max, g_max;
  logic signed [SectW:0] t, dx;

  always_comb begin
    mx    = (red_i > green_i) ? red_i : green_i;
    mn    = (red_i > green_i) ? green_i : red_i;
    if (blue_i > mx) mx = blue_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;
    r_max = (red_i == mx);
    g_max = (green_i == mx);
    dx    = $signed({4'b0, delta});
    if (r_max) begin
      t = $signed({4'b0, green_i}) - $signed({4'b0, blue_i});
    end else if (g_max) begin
      t = (dx <<< 1) + $signed({4'b0, blue_i}) - $signed({4'b0, red_i});
    end else begin
      t = (dx <<< 2) + $signed({4'b0, red_i}) - $signed({4'b0, green_i});
    end
    if (t < 0) t = t + (SectW+1)'(WrapSect) * dx;
    data_d.value = mx;
    data_d.delta = delta;
    data_d.sect  = t[SectW-1:0];
    data_d.gray  = (delta == '0);
  end

  assign ready_o = ~valid_q | ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: design/rgbhsv_scale.sv
// Second stage: scales the hue and saturation numerators and seeds both dividers.
module rgbhsv_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  rgbhsv_pkg::sort_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output rgbhsv_pkg::div_t  data_o
);
  import rgbhsv_pkg::*;

  logic            valid_q;
  div_t            data_q, data_d;
  logic [NumW-1:0] hue_num, sat_num;

  always_comb begin
    hue_num = NumW'(data_i.sect) * NumW'(HueScale);
    sat_num = NumW'(data_i.delta) * NumW'(SatScale);
    data_d.value   = data_i.value;
    data_d.delta   = data_i.delta;
    data_d.gray    = data_i.gray;
    data_d.hue.rem = hue_num[NumW-1:DivSteps];
    data_d.hue.nq  = hue_num[DivSteps-1:0];
    data_d.sat.rem = sat_num[NumW-1:DivSteps];
    data_d.sat.nq  = sat_num[DivSteps-1:0];
  end

  assign ready_o = ~valid_q | ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: design/rgbhsv_div_stage.sv
// One restoring-division stage: one quotient bit each for hue and saturation.
module rgbhsv_div_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  rgbhsv_pkg::div_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output rgbhsv_pkg::div_t data_o
);
  import rgbhsv_pkg::*;

  logic valid_q;
  div_t data_q, data_d;

  always_comb begin
    data_d     = data_i;
    data_d.hue = div_step(data_i.hue, data_i.delta);
    data_d.sat = div_step(data_i.sat, data_i.value);
  end

  assign ready_o = ~valid_q | ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: design/rgbhsv_checker.sv
// Port-level checks for the RGB to HSV converter, bound to the top level.
module rgbhsv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [8:0] hue_degrees_o,
  input logic [7:0] saturation_o,
  input logic [7:0] value_level_o
);

  // output word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(hue_degrees_o) && $stable(saturation_o)
      && $stable(value_level_o))
    else $error("output word changed while stalled");

  // input back-pressure only when the output is holding a word
  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hue_degrees_o < 9'd360)
    else $error("hue out of range");

  a_gray_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturation_o == 8'd0 |-> hue_degrees_o == 9'd0)
    else $error("hue nonzero for gray word");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && value_level_o == 8'd0 |-> saturation_o == 8'd0)
    else $error("saturation nonzero for black word");

endmodule

bind rgb_to_hsv rgbhsv_checker u_checker (.*);

FILE: test/tb_top.sv
// Self-checking testbench for the pipelined RGB to HSV pixel converter.
module tb_top;
  import rgbhsv_pkg::*;

  typedef struct {
    chan_t r;
    chan_t g;
    chan_t b;
    bit    wait_empty;
  } pixel_t;

  typedef struct {
    logic [HueW-1:0] hue;
    chan_t           sat;
    chan_t           val;
  } hsv_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  chan_t           red = '0;
  chan_t           green = '0;
  chan_t           blue = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [HueW-1:0] hue_out;
  chan_t           sat_out;
  chan_t           val_out;

  pixel_t pixel_q[$];
  hsv_t   hsv_q[$];
  int     accepted = 0;
  int     hold_cnt = 0;
  bit     held = 1'b0;
  int     mismatches = 0;
  logic   calm;

  assign calm = (accepted >= 400) && (accepted < 550);

  rgb_to_hsv dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .red_i         (red),
    .green_i       (green),
    .blue_i        (blue),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .hue_degrees_o (hue_out),
    .saturation_o  (sat_out),
    .value_level_o (val_out)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic hsv_t hsv_of(chan_t r, chan_t g, chan_t b);
    hsv_t res;
    int   mx;
    int   mn;
    int   d;
    int   n;
    mx = (r > g) ? int'(r) : int'(g);
    mn = (r > g) ? int'(g) : int'(r);
    if (int'(b) > mx) mx = int'(b);
    if (int'(b) < mn) mn = int'(b);
    d = mx - mn;
    res.val = chan_t'(mx);
    res.sat = (mx != 0) ? chan_t'((d * SatScale) / mx) : '0;
    res.hue = '0;
    if (res.sat != 0) begin
      if (int'(r) == mx) n = HueScale * (int'(g) - int'(b));
      else if (int'(g) == mx) n = HueScale * (2 * d + int'(b) - int'(r));
      else n = HueScale * (4 * d + int'(r) - int'(g));
      if (n < 0) n += WrapSect * HueScale * d;
      res.hue = (HueW)'(n / d);
    end
    return res;
  endfunction

  task automatic add_pixel(chan_t r, chan_t g, chan_t b, bit wait_empty = 1'b0);
    pixel_t p;
    p.r = r;
    p.g = g;
    p.b = b;
    p.wait_empty = wait_empty;
    pixel_q.push_back(p);
  endtask

  // driver
  always @(posedge clk_i) begin
    pixel_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hsv_q.push_back(hsv_of(red, green, blue));
        accepted <= accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (pixel_q.size() > 0 && !(pixel_q[0].wait_empty && hsv_q.size() > 0) &&
            (calm || hold_cnt > 0 || $urandom_range(99) >= 25)) begin
          nxt = pixel_q.pop_front();
          red <= nxt.r;
          green <= nxt.g;
          blue <= nxt.b;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long output stall so the pipeline fills and backs up
  always @(posedge clk_i) begin
    if (!held && accepted >= 200) begin
      hold_cnt <= 80;
      held <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    hsv_t exp_w;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (hsv_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: hue=%0d sat=%0d val=%0d", hue_out, sat_out, val_out);
        end else begin
          exp_w = hsv_q.pop_front();
          if (hue_out !== exp_w.hue || sat_out !== exp_w.sat || val_out !== exp_w.val) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected hue=%0d sat=%0d val=%0d, got hue=%0d sat=%0d val=%0d",
                       exp_w.hue, exp_w.sat, exp_w.val, hue_out, sat_out, val_out);
          end
        end
      end
      out_ready <= (hold_cnt == 0) && (calm || $urandom_range(99) >= 25);
    end
  end

  initial begin
    chan_t v;
    chan_t a;
    chan_t c;
    int    sel;

    // directed: extremes, grays, ties, sector edges, hue wrap
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd128, 8'd128, 8'd128);
    add_pixel(8'd255, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd255, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd255);
    add_pixel(8'd255, 8'd255, 8'd0);
    add_pixel(8'd0, 8'd255, 8'd255);
    add_pixel(8'd255, 8'd0, 8'd255);
    add_pixel(8'd1, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd1, 8'd1);
    add_pixel(8'd1, 8'd0, 8'd1);
    add_pixel(8'd255, 8'd0, 8'd1);
    add_pixel(8'd255, 8'd254, 8'd254);
    add_pixel(8'd254, 8'd255, 8'd255);
    add_pixel(8'd255, 8'd128, 8'd0);
    add_pixel(8'd0, 8'd255, 8'd128);
    add_pixel(8'd128, 8'd0, 8'd255);
    add_pixel(8'd200, 8'd100, 8'd50);
    add_pixel(8'd85, 8'd170, 8'd255);
    add_pixel(8'd1, 8'd2, 8'd3);
    add_pixel(8'd3, 8'd2, 8'd1);
    add_pixel(8'd170, 8'd85, 8'd170);
    add_pixel(8'd2, 8'd1, 8'd255);

    for (int i = 0; i < 700; i++) begin
      v = chan_t'($urandom);
      a = chan_t'($urandom);
      c = chan_t'($urandom);
      sel = $urandom_range(9);
      case (sel)
        0: add_pixel(v, v, v, i == 0 || i == 450);
        1: add_pixel(v, v, a, i == 0 || i == 450);
        2: add_pixel(a, v, v, i == 0 || i == 450);
        3: add_pixel(v, a, v, i == 0 || i == 450);
        4: add_pixel(chan_t'($urandom_range(3)), chan_t'($urandom_range(3)),
                     chan_t'($urandom_range(3)), i == 0 || i == 450);
        5: add_pixel(chan_t'(8'd255 - $urandom_range(3)), chan_t'($urandom_range(255)),
                     chan_t'(8'd255 - $urandom_range(3)), i == 0 || i == 450);
        default: add_pixel(v, a, c, i == 0 || i == 450);
      endcase
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_q.size() > 0 || in_valid || hsv_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && hsv_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: rgb_to_hsv.f
design/rgbhsv_pkg.sv
design/rgbhsv_sort.sv
design/rgbhsv_scale.sv
design/rgbhsv_div_stage.sv
design/rgb_to_hsv.sv
design/rgbhsv_checker.sv
test/tb_top.sv
